// ----- rtl/core/sm_alu_pkg.sv -----
// shared types and constants for the stack machine data stack alu
`default_nettype none
package sm_alu_pkg;
  localparam int unsigned StackDepthDef = 32;
  localparam int unsigned WordW = 32;
  localparam int unsigned OpW = 5;
  localparam int unsigned StW = 2;
  localparam int unsigned DepthOutW = 6;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_DUP = 5'd1, OP_SWAP = 5'd2, OP_OVER = 5'd3, OP_ROT = 5'd4,
    OP_DROP = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_XOR = 5'd8, OP_ADD = 5'd9,
    OP_SUB = 5'd10, OP_MUL = 5'd11, OP_DIVMOD = 5'd12, OP_NEG = 5'd13,
    OP_SHL = 5'd14, OP_SHR = 5'd15, OP_LT = 5'd16, OP_EQ = 5'd17, OP_GT = 5'd18,
    OP_DEPTH = 5'd19
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZ = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_WR2, S_OUT
  } state_t;

  // divider request and reply
  typedef struct packed {
    logic start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [WordW-1:0] quot;
    logic [WordW-1:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/core/stack_machine_data_stack_alu.sv -----
// top level: data stack in one memory with the alu around it
//
// channel  dir  tdata (low bit up)                 handshake
// in_      in   op[4:0], literal[36:5], pad        tvalid/tready
// out_     out  status[1:0], top_value[33:2],      tvalid/tready
//               depth[39:34]
//
// one item at a time: read up to three top entries, one per cycle at the single
// read port, then execute and write back one entry per cycle. a new item is
// taken only after the result of the last one is registered; divmod waits for
// the bit-serial divider. after reset, and before an error result, a clearing
// pass zeroes the memory. the result has its own output register; only a
// second result waits for it.
`default_nettype none
module stack_machine_data_stack_alu #(
  parameter int unsigned STACK_DEPTH = sm_alu_pkg::StackDepthDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic [39:0] in_tdata,   // op, literal
  output logic out_tvalid,
  input  wire logic out_tready,
  output logic [39:0] out_tdata        // status, top_value, depth
);
  import sm_alu_pkg::*;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [WordW-1:0] mem [STACK_DEPTH];
  logic [WordW-1:0] rdata_r;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic [WordW-1:0] wdata;

  state_t state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic [1:0] rd_r, rd_nxt;
  op_t op_r, op_nxt;
  logic [WordW-1:0] lit_r, lit_nxt, a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [WordW-1:0] w2_r, w2_nxt, top_r, top_nxt;
  logic [AW-1:0] w2a_r, w2a_nxt;
  logic [StW-1:0] st_r, st_nxt;
  logic ovld_r, ovld_nxt;
  logic [39:0] odata_r, odata_nxt;
  logic [1:0] need;
  logic [WordW-1:0] prod;
  div_req_t dreq;
  div_rsp_t drsp;

  sm_alu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_comb begin
    unique case (op_r)
      OP_DUP, OP_NEG, OP_SHL, OP_SHR, OP_DROP: need = 2'd1;
      OP_ROT: need = 2'd3;
      OP_PUSH, OP_DEPTH: need = 2'd0;
      default: need = (op_r > OP_DEPTH) ? 2'd0 : 2'd2;
    endcase
  end

  assign prod = a_r * b_r;

  // sequencer
  always_comb begin
    state_nxt = state_r; n_nxt = n_r; clr_nxt = clr_r; rd_nxt = rd_r;
    op_nxt = op_r; lit_nxt = lit_r; a_nxt = a_r; b_nxt = b_r; c_nxt = c_r;
    w2_nxt = w2_r; w2a_nxt = w2a_r; st_nxt = st_r; top_nxt = top_r;
    ovld_nxt = ovld_r; odata_nxt = odata_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    dreq = '{start: 1'b0, dividend: a_r, divisor: b_r};
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_r[AW-1:0];
        if (clr_r == (AW+1)'(STACK_DEPTH - 1)) begin
          state_nxt = (st_r == ST_OK) ? S_IDLE : S_OUT;
        end
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = op_t'(in_tdata[4:0]);
          lit_nxt = in_tdata[36:5];
          rd_nxt = 2'd0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // issue reads of top, second, third in turn; data arrives in the next cycle
        if (rd_r != 2'd0) begin
          unique case (rd_r)
            2'd1: b_nxt = rdata_r;
            2'd2: a_nxt = rdata_r;
            default: c_nxt = rdata_r;
          endcase
        end
        raddr = AW'(n_r - CW'(rd_r) - 1'b1);
        if (rd_r == 2'd3 || CW'(rd_r) >= n_r) state_nxt = S_EXEC;
        rd_nxt = rd_r + 2'd1;
        if (rd_r == 2'd0) begin
          a_nxt = '0; b_nxt = '0; c_nxt = '0;
        end
      end
      S_EXEC: begin
        st_nxt = ST_OK; state_nxt = S_OUT;
        if (n_r < CW'(need)) begin
          st_nxt = ST_UNDER;
        end else begin
          unique case (op_r)
            OP_PUSH, OP_DUP, OP_OVER, OP_DEPTH: begin
              if (n_r == CW'(STACK_DEPTH)) st_nxt = ST_OVER;
              else begin
                we = 1'b1; waddr = AW'(n_r);
                wdata = (op_r == OP_PUSH) ? lit_r : (op_r == OP_DUP) ? b_r :
                        (op_r == OP_OVER) ? a_r : WordW'(n_r);
                top_nxt = wdata; n_nxt = n_r + 1'b1;
              end
            end
            OP_SWAP: begin
              we = 1'b1; waddr = AW'(n_r - 1'b1); wdata = a_r; top_nxt = a_r;
              w2_nxt = b_r; w2a_nxt = AW'(n_r - 2'd2); state_nxt = S_WR2;
            end
            OP_ROT: begin
              we = 1'b1; waddr = AW'(n_r - 1'b1); wdata = c_r; top_nxt = c_r;
              w2_nxt = b_r; w2a_nxt = AW'(n_r - 2'd2); state_nxt = S_WR2;
              // third slot gets old second after this pair
              lit_nxt = a_r;
            end
            OP_DROP: begin
              we = 1'b1; waddr = AW'(n_r - 1'b1); wdata = '0;
              top_nxt = a_r; n_nxt = n_r - 1'b1;
            end
            OP_NEG, OP_SHL, OP_SHR: begin
              we = 1'b1; waddr = AW'(n_r - 1'b1);
              wdata = (op_r == OP_NEG) ? -b_r : (op_r == OP_SHL) ? {b_r[30:0], 1'b0}
                      : {b_r[31], b_r[31:1]};
              top_nxt = wdata;
            end
            OP_DIVMOD: begin
              if (b_r == '0) st_nxt = ST_DIVZ;
              else begin
                dreq.start = 1'b1; state_nxt = S_DIV;
              end
            end
            OP_AND, OP_OR, OP_XOR, OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_EQ, OP_GT: begin
              unique case (op_r)
                OP_AND: wdata = a_r & b_r;
                OP_OR: wdata = a_r | b_r;
                OP_XOR: wdata = a_r ^ b_r;
                OP_ADD: wdata = a_r + b_r;
                OP_SUB: wdata = a_r - b_r;
                OP_MUL: wdata = prod;
                OP_LT: wdata = WordW'($signed(a_r) < $signed(b_r));
                OP_EQ: wdata = WordW'(a_r == b_r);
                default: wdata = WordW'($signed(a_r) > $signed(b_r));
              endcase
              we = 1'b1; waddr = AW'(n_r - 2'd2); top_nxt = wdata;
              w2_nxt = '0; w2a_nxt = AW'(n_r - 1'b1); state_nxt = S_WR2;
              n_nxt = n_r - 1'b1;
            end
            default: top_nxt = b_r;
          endcase
        end
        if (st_nxt != ST_OK) begin
          n_nxt = '0; top_nxt = '0; clr_nxt = '0; state_nxt = S_CLEAR;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          we = 1'b1; waddr = AW'(n_r - 1'b1); wdata = drsp.rem; top_nxt = drsp.rem;
          w2_nxt = drsp.quot; w2a_nxt = AW'(n_r - 2'd2); state_nxt = S_WR2;
        end
      end
      S_WR2: begin
        we = 1'b1; waddr = w2a_r; wdata = w2_r; state_nxt = S_OUT;
        if (op_r == OP_ROT && w2a_r == AW'(n_r - 2'd2)) begin
          // second pass writes the third slot
          w2_nxt = lit_r; w2a_nxt = AW'(n_r - 2'd3);
          state_nxt = S_WR2;
        end
      end
      S_OUT: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt = 1'b1; odata_nxt = {DepthOutW'(n_r), top_r, st_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (n_nxt == '0 && state_r == S_EXEC) top_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; n_r <= '0; clr_r <= '0; ovld_r <= 1'b0; st_r <= ST_OK;
      rd_r <= '0; top_r <= '0; odata_r <= '0;
    end else begin
      state_r <= state_nxt; n_r <= n_nxt; clr_r <= clr_nxt; ovld_r <= ovld_nxt;
      st_r <= st_nxt; rd_r <= rd_nxt; top_r <= top_nxt; odata_r <= odata_nxt;
    end
    op_r <= op_nxt; lit_r <= lit_nxt; a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt;
    w2_r <= w2_nxt; w2a_r <= w2a_nxt;
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata = odata_r;
endmodule
`default_nettype wire

// ----- rtl/core/sm_alu_div.sv -----
// radix-2 restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module sm_alu_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sm_alu_pkg::div_req_t req,
  output sm_alu_pkg::div_rsp_t rsp
);
  import sm_alu_pkg::*;
  logic [WordW-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [WordW:0] r_r, r_nxt, trial;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  // load the operands on start, else one shift-subtract step while busy
  always_comb begin
    q_nxt = q_r; d_nxt = d_r; r_nxt = r_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r[WordW-1:0], q_r[WordW-1]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.dividend; d_nxt = req.divisor; r_nxt = '0;
      cnt_nxt = 6'(WordW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[WordW]) begin
        r_nxt = {r_r[WordW-1:0], q_r[WordW-1]};
        q_nxt = {q_r[WordW-2:0], 1'b0};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[WordW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; r_r <= r_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem = r_r[WordW-1:0];
endmodule
`default_nettype wire

// ----- rtl/core/sm_alu_checker.sv -----
// port-level checks for the stack alu, bound to the top level
`default_nettype none
module sm_alu_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [39:0] out_tdata
);
  // error result shows an empty stack
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[39:2] == '0)
    else $error("error result with nonempty stack");
  // empty stack shows zero top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39:34] == 6'd0 |-> out_tdata[33:2] == '0)
    else $error("empty stack with nonzero top");
  // one item at a time: no item right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an item was taken");
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
endmodule

bind stack_machine_data_stack_alu sm_alu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
